// ===== hdl/rtctk_pkg.sv =====
package rtctk_pkg;

	localparam logic [2:0] OP_TICK        = 3'd0;
	localparam logic [2:0] OP_SET_TIME    = 3'd1;
	localparam logic [2:0] OP_SET_CNTDOWN = 3'd2;
	localparam logic [2:0] OP_READ_TIME   = 3'd3;
	localparam logic [2:0] OP_READ_ACC    = 3'd4;
	localparam logic [2:0] OP_READ_CNTDN  = 3'd5;

	localparam logic [19:0] TICK_US       = 20'd31250;
	localparam logic [19:0] US_PER_SECOND = 20'd1000000;

	// Reciprocal of 15625 scaled by 2^33, rounded up; exact for 19-bit dividends.
	localparam logic [19:0] RECIP_15625 = 20'd549756;

	typedef struct packed {
		logic [31:0] seconds;
		logic [19:0] microseconds;
		logic [31:0] countdown;
	} state_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [31:0] new_seconds;
		logic [5:0]  tick_count;
		logic [31:0] new_countdown;
		logic [20:0] interp;
	} item_t;

	typedef struct packed {
		logic [31:0] seconds;
		logic [21:0] microseconds;
		logic [31:0] countdown;
		logic        tick_event;
		logic        countdown_event;
	} result_t;

	// Whole ticks contained in a microseconds value (value / 31250).
	function automatic logic [5:0] whole_ticks(input logic [19:0] us);
		logic [38:0] prod;
		begin
			prod = 39'(us[19:1]) * 39'(RECIP_15625);
			return prod[38:33];
		end
	endfunction

	// Microseconds covered by a sub-tick count (count * 31250 / 1024, floor).
	function automatic logic [20:0] sub_tick_us(input logic [15:0] count);
		logic [30:0] prod;
		begin
			prod = 31'(count) * 31'(TICK_US);
			return prod[30:10];
		end
	endfunction

endpackage

// ===== hdl/rtctk_step.sv =====
module rtctk_step (
	input  logic              sleep_mode,
	input  rtctk_pkg::item_t  item,
	input  rtctk_pkg::state_t state,
	output rtctk_pkg::state_t state_next,
	output rtctk_pkg::result_t result
);

	logic [20:0] us_tick;
	logic [19:0] us_wrapped;
	logic [31:0] cnt_dec;
	logic        tick_ev;
	logic        cd_ev;

	assign us_tick    = 21'(state.microseconds) + 21'(rtctk_pkg::TICK_US);
	assign us_wrapped = (us_tick >= 21'(rtctk_pkg::US_PER_SECOND)) ?
		20'(us_tick - 21'(rtctk_pkg::US_PER_SECOND)) : us_tick[19:0];
	assign cnt_dec    = state.countdown - 32'd1;

	always_comb begin
		state_next = state;
		tick_ev    = 1'b0;
		cd_ev      = 1'b0;
		unique case (item.operation)
			rtctk_pkg::OP_TICK: begin
				if (!sleep_mode) begin
					state_next.microseconds = us_wrapped;
					if (us_tick >= 21'(rtctk_pkg::US_PER_SECOND)) begin
						state_next.seconds = state.seconds + 32'd1;
					end
					tick_ev = 1'b1;
					if (state.countdown != 32'd0) begin
						state_next.countdown = cnt_dec;
						cd_ev = (cnt_dec == 32'd0);
					end
				end else begin
					state_next.seconds = state.seconds + 32'd2;
				end
			end
			rtctk_pkg::OP_SET_TIME: begin
				state_next.seconds      = item.new_seconds;
				state_next.microseconds = 20'(item.tick_count) * rtctk_pkg::TICK_US;
			end
			rtctk_pkg::OP_SET_CNTDOWN: begin
				state_next.countdown = item.new_countdown;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		result.seconds         = state_next.seconds;
		result.microseconds    = 22'(state_next.microseconds);
		result.countdown       = state_next.countdown;
		result.tick_event      = tick_ev;
		result.countdown_event = cd_ev;
		if (item.operation == rtctk_pkg::OP_READ_ACC) begin
			result.microseconds = 22'(state_next.microseconds) + 22'(item.interp);
		end
	end

endmodule

// ===== hdl/rtc_tick_timekeeper_unit.sv =====
// Real-time clock timekeeper. Time is kept as 32-bit seconds and 20-bit microseconds,
// with a 32-bit tick countdown. Every input word (tick, set time, set countdown, read
// time, read accurate time, read countdown) returns exactly one result word holding
// the stored time and countdown after the operation. A word passes an input register
// and the state update into the result register. A new word is taken every cycle
// unless out_stall holds a waiting result; the state feedback through the single
// update stage sets that rate. The result register lets a new word be taken while a
// finished one waits. The user must write the sleep_mode register, through cfg_we and
// cfg_wdata, only while the unit is idle (not enforced); it selects 2-second ticks.
module rtc_tick_timekeeper_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  operation,
	input  logic [31:0] new_seconds,
	input  logic [19:0] new_microseconds,
	input  logic [31:0] new_countdown,
	input  logic [15:0] sub_tick_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] seconds_out,
	output logic [21:0] microseconds_out,
	output logic [31:0] countdown_left,
	output logic        tick_event,
	output logic        countdown_event
);

	logic               sleep_mode_q;
	rtctk_pkg::item_t   item_in;
	rtctk_pkg::item_t   item_s1;
	logic               valid_s1;
	rtctk_pkg::state_t  state_q;
	rtctk_pkg::state_t  state_next;
	rtctk_pkg::result_t result_next;
	rtctk_pkg::result_t result_s2;
	logic               valid_s2;
	logic               advance;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_comb begin
		item_in.operation     = operation;
		item_in.new_seconds   = new_seconds;
		item_in.tick_count    = rtctk_pkg::whole_ticks(new_microseconds);
		item_in.new_countdown = new_countdown;
		item_in.interp        = rtctk_pkg::sub_tick_us(sub_tick_count);
	end

	rtctk_step u_step (
		.sleep_mode (sleep_mode_q),
		.item       (item_s1),
		.state      (state_q),
		.state_next (state_next),
		.result     (result_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sleep_mode_q <= 1'b0;
		end else if (cfg_we) begin
			sleep_mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			state_q  <= state_next;
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_next;
		end
	end

	assign out_valid        = valid_s2;
	assign seconds_out      = result_s2.seconds;
	assign microseconds_out = result_s2.microseconds;
	assign countdown_left   = result_s2.countdown;
	assign tick_event       = result_s2.tick_event;
	assign countdown_event  = result_s2.countdown_event;

endmodule
